// ===== hdl/vibration_magnitude_mean_top_defines.svh =====
`ifndef VIBRATION_MAGNITUDE_MEAN_TOP_DEFINES_SVH
`define VIBRATION_MAGNITUDE_MEAN_TOP_DEFINES_SVH

// Both macros sample on the rising edge of clk and stay quiet while rst_n is low.
// The first checks the consequent in the same cycle as the antecedent.
`define VMM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The second checks the consequent in the cycle after the antecedent.
`define VMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/vmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vmm_pkg;

  localparam int AXIS_W   = 16;
  localparam int IN_W     = 3 * AXIS_W;
  localparam int SQ_W     = 32;
  localparam int ROOT_W   = 16;
  localparam int MEAN_W   = 16;
  localparam int CFG_W    = 11;
  localparam int FIFO_DEPTH = 2;

  localparam logic [ROOT_W-1:0] ONE_G            = 16'd16384;
  localparam logic [CFG_W-1:0]  SAMPLE_COUNT_RST = 11'd16;
  localparam logic [MEAN_W-1:0] MEAN_MAX         = 16'd40371;

  typedef logic [SQ_W-1:0] sumsq_t;

  // The x axis sits in the lowest bits of the packed item.
  typedef struct packed {
    logic signed [AXIS_W-1:0] accel_z;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_x;
  } sample_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQRT,
    B_ACC,
    B_CHK,
    B_DIV,
    B_HOLD
  } back_state_t;

endpackage

`default_nettype wire

// ===== hdl/vmm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vmm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  vmm_pkg::sample_t in_sample,
  output logic             sq_valid,
  input  logic             sq_ready,
  output vmm_pkg::sumsq_t  sq_data
);
  import vmm_pkg::*;

  localparam logic [1:0] LAST_AXIS = 2'd2;

  front_state_t state_r, state_nxt;
  sample_t      sample_r;
  sumsq_t       acc_r;
  logic [1:0]   axis_r;
  logic [AXIS_W-1:0] axis_val;
  logic [AXIS_W-1:0] axis_abs;
  logic [SQ_W-1:0]   axis_sq;
  logic              accept;

  always_comb begin
    case (axis_r)
      2'd0:    axis_val = sample_r.accel_x;
      2'd1:    axis_val = sample_r.accel_y;
      default: axis_val = sample_r.accel_z;
    endcase
  end

  // The most negative value negates to 0x8000, which read unsigned is exact.
  assign axis_abs = axis_val[AXIS_W-1] ? (~axis_val + 1'b1) : axis_val;
  assign axis_sq  = {{AXIS_W{1'b0}}, axis_abs} * {{AXIS_W{1'b0}}, axis_abs};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) state_nxt = F_MUL;
      end
      F_MUL: begin
        if (axis_r == LAST_AXIS) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (sq_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == F_IDLE);
    sq_valid = (state_r == F_PUSH);
  end

  assign accept  = in_valid && in_ready;
  assign sq_data = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
      acc_r    <= '0;
      axis_r   <= '0;
    end else if (state_r == F_MUL) begin
      acc_r  <= acc_r + axis_sq;
      axis_r <= axis_r + 2'd1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/vmm_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vmm_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  vmm_pkg::sumsq_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output vmm_pkg::sumsq_t rd_data
);
  import vmm_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);

  sumsq_t        mem_r [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW:0]   count_r;
  logic          push;
  logic          pop;

  assign wr_ready = (count_r != (AW + 1)'(FIFO_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

`default_nettype wire

// ===== hdl/vmm_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vmm_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  vmm_pkg::sumsq_t            operand,
  output logic                       done,
  output logic [vmm_pkg::ROOT_W-1:0] root
);
  import vmm_pkg::*;

  localparam int ITER = ROOT_W;
  localparam int CNTW = $clog2(ITER);
  localparam int RW   = ROOT_W + 4;

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  sumsq_t          op_r;
  logic [RW-1:0]   rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [RW-1:0]   rem_sh;
  logic [RW-1:0]   trial;
  logic            ge;

  // One result bit per cycle: bring down two operand bits and try 4*root+1.
  assign rem_sh = {rem_r[RW-3:0], op_r[SQ_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign done   = done_r;
  assign root   = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNTW'(ITER - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= operand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      op_r   <= {op_r[SQ_W-3:0], 2'b00};
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], ge};
      cnt_r  <= cnt_r + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/vmm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vmm_div #(
  parameter int DW = 27,
  parameter int VW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [DW-1:0]   q_r;
  logic [VW-1:0]   rem_r;
  logic [VW-1:0]   div_r;
  logic [VW:0]     rem_sh;
  logic [VW:0]     rem_sub;
  logic            ge;

  // Restoring division: the dividend shifts out of q_r while quotient bits shift in.
  assign rem_sh  = {rem_r, q_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign ge      = (rem_sh >= {1'b0, div_r});
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNTW'(DW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      div_r <= divisor;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[DW-2:0], ge};
      rem_r <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
      cnt_r <= cnt_r + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/vmm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vmm_back #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       sq_valid,
  output logic                       sq_ready,
  input  vmm_pkg::sumsq_t            sq_data,
  input  logic [vmm_pkg::CFG_W-1:0]  sample_count,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [vmm_pkg::MEAN_W-1:0] out_mean
);
  import vmm_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = CW + ROOT_W;
  localparam int EW = (CFG_W > CW) ? CFG_W : CW;

  back_state_t       state_r, state_nxt;
  logic [ROOT_W-1:0] dev_r;
  logic [SW-1:0]     sum_r;
  logic [CW-1:0]     cnt_r;
  logic              out_valid_r;
  logic [MEAN_W-1:0] out_mean_r;

  logic [EW-1:0]     cfg_ext;
  logic [EW-1:0]     eff_cnt;
  logic              block_full;
  logic              slot_free;
  logic              sqrt_start;
  logic              sqrt_done;
  logic [ROOT_W-1:0] root;
  logic              div_start;
  logic              div_done;
  logic [SW-1:0]     quotient;
  logic              load_out;

  // A count of zero means one sample per result; counts above the limit saturate.
  always_comb begin
    cfg_ext = EW'(sample_count);
    if (cfg_ext == '0) begin
      eff_cnt = EW'(1);
    end else if (cfg_ext > EW'(MAX_SAMPLES)) begin
      eff_cnt = EW'(MAX_SAMPLES);
    end else begin
      eff_cnt = cfg_ext;
    end
  end

  assign block_full = (EW'(cnt_r) >= eff_cnt);
  assign slot_free  = !out_valid_r || out_ready;

  vmm_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sqrt_start),
    .operand (sq_data),
    .done    (sqrt_done),
    .root    (root)
  );

  vmm_div #(
    .DW (SW),
    .VW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (sq_valid) state_nxt = B_SQRT;
      end
      B_SQRT: begin
        if (sqrt_done) state_nxt = B_ACC;
      end
      B_ACC:  state_nxt = B_CHK;
      B_CHK: begin
        state_nxt = block_full ? B_DIV : B_IDLE;
      end
      B_DIV: begin
        if (div_done) state_nxt = B_HOLD;
      end
      B_HOLD: begin
        if (slot_free) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    sq_ready   = (state_r == B_IDLE);
    sqrt_start = (state_r == B_IDLE) && sq_valid;
    div_start  = (state_r == B_CHK) && block_full;
    load_out   = (state_r == B_HOLD) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_ACC) begin
        sum_r <= sum_r + SW'(dev_r);
        cnt_r <= cnt_r + 1'b1;
      end else if (div_start) begin
        // The divider has taken both operands at this edge.
        sum_r <= '0;
        cnt_r <= '0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_SQRT && sqrt_done) begin
      dev_r <= (root >= ONE_G) ? (root - ONE_G) : (ONE_G - root);
    end
    if (load_out) begin
      out_mean_r <= quotient[MEAN_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_mean  = out_mean_r;

endmodule

`default_nettype wire

// ===== hdl/vibration_magnitude_mean_top.sv =====
// Vibration magnitude mean: mean absolute deviation of |a| from 1 g.
// Input stream in_*: one three-axis sample per item, 16384 counts per g.
// Output stream out_*: one mean every sample_count samples, in 1/16384 g.
// Configuration cfg_*: writes sample_count; cfg_ready is always high. The user
// must write only while no sample is in flight; the block does not enforce it.
// Front end: takes a sample, squares the three axes one after another on one
// shared multiplier and hands the sum of squares to a two-entry queue; it takes
// no new sample until the queue has taken that sum.
// Back end: a bit-serial square root limits the sustained sample rate. The
// sample that closes a block also runs a restoring divider on a CW+16 bit
// dividend, CW = clog2(MAX_SAMPLES+1), i.e. 27 bits at the default; out_tvalid
// rises once the divider is done and the output register is free.
// Reset (rst_n low at a clock edge) empties the queue, clears the running
// sum and count and sets sample_count to 16. When out_tready is low the
// result stays in the output register; the front end keeps taking samples
// until the queue fills, then in_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module vibration_magnitude_mean_top #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  input  logic [vmm_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // vibration_mean [15:0]
  output logic [vmm_pkg::MEAN_W-1:0] out_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [vmm_pkg::CFG_W-1:0]  cfg_data
);
  import vmm_pkg::*;

  logic [CFG_W-1:0] sample_count_r;
  sample_t          in_sample;
  logic             push_valid;
  logic             push_ready;
  sumsq_t           push_data;
  logic             pop_valid;
  logic             pop_ready;
  sumsq_t           pop_data;

  assign cfg_ready = 1'b1;
  assign in_sample = sample_t'(in_tdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= SAMPLE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      sample_count_r <= cfg_data;
    end
  end

  vmm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_sample),
    .sq_valid  (push_valid),
    .sq_ready  (push_ready),
    .sq_data   (push_data)
  );

  vmm_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  vmm_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .sq_valid     (pop_valid),
    .sq_ready     (pop_ready),
    .sq_data      (pop_data),
    .sample_count (sample_count_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_mean     (out_tdata)
  );

endmodule

`default_nettype wire

// ===== hdl/vmm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "vibration_magnitude_mean_top_defines.svh"

module vmm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [vmm_pkg::MEAN_W-1:0] out_tdata
);
  import vmm_pkg::*;

  `VMM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `VMM_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "stalled result changed")
  // The front end squares an item's axes one after another, so it cannot take two in a row.
  `VMM_ASSERT_NEXT(a_in_gap, in_tvalid && in_tready, !in_tready, "front end took items back to back")
  // No mean can exceed the largest deviation a sample can produce.
  `VMM_ASSERT_SAME(a_mean_range, out_tvalid, out_tdata <= MEAN_MAX, "mean out of range")

endmodule

bind vibration_magnitude_mean_top vmm_checker u_vmm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
